[hdl/depq_pkg.sv]
// Shared types and codes for the double-ended priority queue.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package depq_pkg;

  localparam int WORD_W = 32;
  localparam int OCC_W  = 7;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DEL_MAX = 2'd1,
    ACT_DEL_MIN = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_PUBLISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic publish;
  } cmd_t;

endpackage

[hdl/depq_ctrl.sv]
// Sequencer for the queue: capture, apply, publish.
// Depends on depq_pkg; drives the datapath through depq_pkg::cmd_t.
`timescale 1ns / 1ps

module depq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output depq_pkg::cmd_t cmd
);
  import depq_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_PUBLISH;
      end
      S_PUBLISH: begin
        if (!out_valid || !out_stall) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (cmd.publish) out_valid_next = 1'b1;
  end

`ifndef SYNTHESIS
  a_capture_then_apply: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.apply)
    else $error("apply did not follow capture");
  a_publish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("published item not presented");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.apply, cmd.publish}))
    else $error("overlapping commands");
`endif

endmodule

[hdl/depq_datapath.sv]
// Sorted row of value cells, count, and result registers.
// Depends on depq_pkg; commanded by depq_ctrl.
`timescale 1ns / 1ps

module depq_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  depq_pkg::cmd_t          cmd,
  input  logic [1:0]              action,
  input  depq_pkg::word_t         value,
  output depq_pkg::word_t         largest,
  output depq_pkg::word_t         smallest,
  output logic [depq_pkg::OCC_W-1:0] occupancy,
  output logic [1:0]              status
);
  import depq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  action_t          act_q;
  word_t            val_q;
  word_t            cells [CAPACITY];
  word_t            cells_next [CAPACITY];
  logic [CNT_W-1:0] count, count_next;
  status_t          st_q, st_next;
  logic [CAPACITY-1:0] gt;
  logic             is_full, is_empty;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);
  assign cnt_m1   = count - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action_t'(action);
      val_q <= value;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign gt[i] = (CNT_W'(i) < count) && (cells[i] > val_q);

    always_comb begin
      cells_next[i] = cells[i];
      case (act_q)
        ACT_INSERT: begin
          if (!is_full) begin
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
              cells_next[i] = cells[(i > 0) ? i - 1 : 0];
            end else if (gt[i] || CNT_W'(i) == count) begin
              cells_next[i] = val_q;
            end
          end
        end
        ACT_DEL_MIN: begin
          if (i < CAPACITY - 1) begin
            cells_next[i] = cells[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
        default: cells_next[i] = cells[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < CAPACITY; i++) cells[i] <= cells_next[i];
      st_q <= st_next;
    end
  end

  always_comb begin
    count_next = count;
    st_next    = ST_DONE;
    case (act_q) inside
      ACT_INSERT: begin
        if (is_full) st_next = ST_FULL;
        else count_next = count + CNT_W'(1);
      end
      ACT_DEL_MAX, ACT_DEL_MIN: begin
        if (is_empty) st_next = ST_EMPTY;
        else count_next = cnt_m1;
      end
      default: st_next = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      largest   <= is_empty ? word_t'(0) : cells[cnt_m1[IDX_W-1:0]];
      smallest  <= is_empty ? word_t'(0) : cells[0];
      occupancy <= occ_wide[OCC_W-1:0];
      status    <= st_q;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count above capacity");
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.apply |=> $stable(count))
    else $error("count changed outside apply");
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && act_q == ACT_INSERT && is_full) |=> $stable(count) && st_q == ST_FULL)
    else $error("insert into full store not dropped");
`endif

endmodule

[hdl/double_ended_priority_queue.sv]
// Double-ended priority queue top level: sequencer plus sorted cell row.
// Each input item is captured, applied to the sorted cell row, then published
// into the result registers, where out_valid rises for the receiver.
// No new item is accepted until the previous one is published (capture, apply,
// publish steps of the sequencer); publish waits while the output is stalled.
// Reset clears the count and handshake state; cell contents are not cleared.
`timescale 1ns / 1ps

module double_ended_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  depq_pkg::word_t             value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output depq_pkg::word_t             largest,
  output depq_pkg::word_t             smallest,
  output logic [depq_pkg::OCC_W-1:0]  occupancy,
  output logic [1:0]                  status
);
  import depq_pkg::*;

  cmd_t cmd;

  depq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  depq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .action    (action),
    .value     (value),
    .largest   (largest),
    .smallest  (smallest),
    .occupancy (occupancy),
    .status    (status)
  );

endmodule
